// ===== hdl/adip_pkg.sv =====
// ----------------------------------------------------------------------------
// adip_pkg
// Types and codes shared by the decimal integer parser and its channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package adip_pkg;

   localparam int unsigned TIMEOUT_W   = 24;
   localparam int unsigned ELAPSED_W   = 25;
   localparam int unsigned NUMBER_W    = 32;
   localparam int unsigned BYTE_W      = 8;
   localparam int unsigned MULADD_W    = NUMBER_W + 4;

   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 24'd1000;

   localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [BYTE_W-1:0] CHAR_NINE  = 8'h39;
   localparam logic [BYTE_W-1:0] CHAR_MINUS = 8'h2D;

   typedef enum logic [1:0] {
      CMD_START = 2'd0,
      CMD_BYTE  = 2'd1,
      CMD_TICK  = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   typedef enum logic [0:0] {
      STATUS_DONE    = 1'b0,
      STATUS_TIMEOUT = 1'b1
   } status_type;

   typedef enum logic [1:0] {
      PH_IDLE  = 2'b01,
      PH_ARMED = 2'b10
   } phase_type;

   typedef struct packed {
      cmd_type           cmd;
      logic [BYTE_W-1:0] rx_byte;
   } req_payload_type;

   typedef struct packed {
      logic signed [NUMBER_W-1:0] number;
      status_type                 status;
      logic                       overflow;
      logic [BYTE_W-1:0]          terminator;
   } rsp_payload_type;

endpackage

// ===== hdl/adip_stream_if.sv =====
// ----------------------------------------------------------------------------
// adip_stream_if
// Valid/ready channel that moves one payload per transaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface adip_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== hdl/ascii_decimal_int_parser.sv =====
// The byte or tick that ends the parse is registered in the input stage, and its result then in the result register.
// One request transaction is taken per cycle unless the input stage stalls; the state update is combinational logic.
// A request stalls only when it yields a result while the result register is still full.
// Reset clears the parser to idle, empties both register stages and sets the timeout to 1000.
// ----------------------------------------------------------------------------
// ascii_decimal_int_parser
// Parses a signed decimal integer from a byte stream, with a tick-based timeout.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ascii_decimal_int_parser (
   input  logic                               clock,
   input  logic                               reset,
   adip_stream_if.sink                        req_chan,
   adip_stream_if.source                      rsp_chan,
   input  logic                               csr_wr_en,
   input  logic [adip_pkg::TIMEOUT_W-1:0]     csr_wr_data
);
   import adip_pkg::*;

   logic [TIMEOUT_W-1:0] timeout_ff;

   logic              s1_valid_ff, s1_valid_in;
   cmd_type           s1_cmd_ff;
   logic [BYTE_W-1:0] s1_byte_ff;

   phase_type               phase_ff, phase_in;
   logic [NUMBER_W-1:0]     acc_ff, acc_in;
   logic                    neg_ff, neg_in;
   logic                    wrap_ff, wrap_in;
   logic                    seen_ff, seen_in;
   logic [ELAPSED_W-1:0]    elapsed_ff, elapsed_in;

   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_ff, rsp_in;

   logic                 req_take;
   logic                 out_free;
   logic                 s1_adv;
   logic                 has_result;
   logic                 is_digit;
   logic [MULADD_W-1:0]  muladd;
   logic [ELAPSED_W-1:0] elapsed_inc;

   assign req_take = req_chan.valid && req_chan.ready;
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign is_digit = (s1_byte_ff >= CHAR_ZERO) && (s1_byte_ff <= CHAR_NINE);
   assign muladd   = {1'b0, acc_ff, 3'b000} + {3'b000, acc_ff, 1'b0}
                   + {{(MULADD_W-4){1'b0}}, 4'(s1_byte_ff - CHAR_ZERO)};
   assign elapsed_inc = elapsed_ff + ELAPSED_W'(1);

   always_comb begin
      phase_in   = phase_ff;
      acc_in     = acc_ff;
      neg_in     = neg_ff;
      wrap_in    = wrap_ff;
      seen_in    = seen_ff;
      elapsed_in = elapsed_ff;
      has_result = 1'b0;
      rsp_in.number     = '0;
      rsp_in.status     = STATUS_DONE;
      rsp_in.overflow   = 1'b0;
      rsp_in.terminator = '0;
      case (s1_cmd_ff)
         CMD_START: begin
            phase_in   = PH_ARMED;
            acc_in     = '0;
            neg_in     = 1'b0;
            wrap_in    = 1'b0;
            seen_in    = 1'b0;
            elapsed_in = '0;
         end
         CMD_BYTE: begin
            if (phase_ff == PH_ARMED) begin
               if (is_digit) begin
                  acc_in  = muladd[NUMBER_W-1:0];
                  wrap_in = wrap_ff || (muladd[MULADD_W-1:NUMBER_W] != '0);
                  seen_in = 1'b1;
               end else if ((s1_byte_ff == CHAR_MINUS) && !seen_ff) begin
                  neg_in  = 1'b1;
                  seen_in = 1'b1;
               end else if (seen_ff) begin
                  has_result        = 1'b1;
                  phase_in          = PH_IDLE;
                  rsp_in.number     = neg_ff ? -$signed(acc_ff) : $signed(acc_ff);
                  rsp_in.overflow   = wrap_ff;
                  rsp_in.terminator = s1_byte_ff;
               end
            end
         end
         CMD_TICK: begin
            if (phase_ff == PH_ARMED) begin
               elapsed_in = elapsed_inc;
               if (elapsed_inc > {1'b0, timeout_ff}) begin
                  has_result    = 1'b1;
                  phase_in      = PH_IDLE;
                  rsp_in.status = STATUS_TIMEOUT;
               end
            end
         end
         default: begin
         end
      endcase
   end

   assign s1_adv          = s1_valid_ff && (!has_result || out_free);
   assign req_chan.ready  = !s1_valid_ff || s1_adv;
   assign s1_valid_in     = req_take || (s1_valid_ff && !s1_adv);
   assign rsp_valid_in    = (s1_adv && has_result) || (rsp_valid_ff && !rsp_chan.ready);
   assign rsp_chan.valid  = rsp_valid_ff;
   assign rsp_chan.payload = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff   <= TIMEOUT_RESET;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         phase_ff     <= PH_IDLE;
         acc_ff       <= '0;
         neg_ff       <= 1'b0;
         wrap_ff      <= 1'b0;
         seen_ff      <= 1'b0;
         elapsed_ff   <= '0;
      end else begin
         if (csr_wr_en) begin
            timeout_ff <= csr_wr_data;
         end
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (s1_adv) begin
            phase_ff   <= phase_in;
            acc_ff     <= acc_in;
            neg_ff     <= neg_in;
            wrap_ff    <= wrap_in;
            seen_ff    <= seen_in;
            elapsed_ff <= elapsed_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_cmd_ff  <= req_chan.payload.cmd;
         s1_byte_ff <= req_chan.payload.rx_byte;
      end
      if (s1_adv && has_result) begin
         rsp_ff <= rsp_in;
      end
   end

   // A loaded result always returns the parser to idle.
   a_result_idles: assert property (@(posedge clock) disable iff (reset)
      (s1_adv && has_result) |=> (phase_ff == PH_IDLE))
      else $error("parser not idle after a result");

   // A timeout result never carries a number, overflow or terminator.
   a_timeout_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_ff.status == STATUS_TIMEOUT)) |->
      ((rsp_ff.number == '0) && !rsp_ff.overflow && (rsp_ff.terminator == '0)))
      else $error("timeout result carries payload");

   // A stalled request in the input stage is kept unchanged.
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_adv) |=>
      (s1_valid_ff && $stable(s1_cmd_ff) && $stable(s1_byte_ff)))
      else $error("stalled request lost");

   // An empty input stage always takes a request.
   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      !s1_valid_ff |-> req_chan.ready)
      else $error("empty input stage not ready");

endmodule
